@@ rtl/lab_pkg.sv @@
// ----------------------------------------------------------------------------
// lab_pkg: shared definitions for the lux average brightness map
// Holds the register map, reset values, datapath widths, the controller
// state type and the command and status structs between controller and
// datapath.
// ----------------------------------------------------------------------------
package lab_pkg;

   // Default length of the moving-average window.
   localparam int WINDOW_LEN_DEFAULT = 30;

   // Field widths.
   localparam int TIME_W   = 32;
   localparam int LUX_W    = 16;
   localparam int BRIGHT_W = 8;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   // Range divider: dividend and divisor widths, two quotient bits a cycle.
   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 16;

   // Signed widths of the range map.
   localparam int DIFF_W = LUX_W + 1;
   localparam int SPAN_W = BRIGHT_W + 1;
   localparam int PROD_W = DIFF_W + SPAN_W;

   // Register reset values.
   localparam logic [15:0] PERIOD_RESET   = 16'd200;
   localparam logic [15:0] LOW_RESET      = 16'd1;
   localparam logic [15:0] HIGH_RESET     = 16'd17000;
   localparam logic [7:0]  FLOOR_RESET    = 8'd1;
   localparam logic [7:0]  CEILING_RESET  = 8'd100;

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_SAMPLE_PERIOD  = 3'd0,
      REG_LUX_RANGE_LOW  = 3'd1,
      REG_LUX_RANGE_HIGH = 3'd2,
      REG_BRIGHT_FLOOR   = 3'd3,
      REG_BRIGHT_CEILING = 3'd4
   } reg_index_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_AVERAGE,
      ST_MAP_MUL,
      ST_MAP_START,
      ST_MAP_WAIT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        ram_read;
      logic        update;
      logic        div_start;
      logic        avg_load;
      logic        mul_load;
      logic        out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic take;
      logic div_busy;
      logic span_zero;
      logic out_free;
   } status_type;

endpackage

@@ rtl/lab_req_if.sv @@
// ----------------------------------------------------------------------------
// lab_req_if: input channel of the lux average brightness map
// Carries the millisecond time stamp and the light reading of one word.
// ----------------------------------------------------------------------------
interface lab_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [15:0] lux;

   modport source (output valid, output now_ms, output lux, input ready);
   modport sink (input valid, input now_ms, input lux, output ready);
endinterface

@@ rtl/lab_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lab_rsp_if: result channel of the lux average brightness map
// Carries the window average and the mapped brightness of one word.
// ----------------------------------------------------------------------------
interface lab_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] average_lux;
   logic [7:0]  brightness;

   modport source (output valid, output average_lux, output brightness, input ready);
   modport sink (input valid, input average_lux, input brightness, output ready);
endinterface

@@ rtl/lux_average_brightness_map.sv @@
// ----------------------------------------------------------------------------
// lux_average_brightness_map: moving-average lux filter with brightness map
//
//   Channel   Direction  Word contents                 Accepted when
//   req_bus   in         now_ms[31:0], lux[15:0]       valid && ready
//   rsp_bus   out        average_lux[15:0],            valid && ready
//                        brightness[7:0]
//   csr       in/out     APB registers at 4*index      psel && penable && pwrite
//
// An item too early for a sample is accepted while idle and gives no word.
// A sampled item runs window update, average, range multiply, division and
// hand-off, skipping the division for an empty lux range; the range divider
// does 12 passes at two bits a cycle; the average is a reciprocal multiply.
// One item is at work at a time; the next is taken while its result waits.
// Reset clears the window at once through per-entry valid bits.
// A stalled result holds the block in its final step until it is taken.
// ----------------------------------------------------------------------------
module lux_average_brightness_map #(
   parameter int WINDOW_LEN = lab_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   lab_req_if.sink                     req_bus,
   lab_rsp_if.source                   rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lab_pkg::CSR_AW-1:0]  paddr,
   input  logic [lab_pkg::CSR_DW-1:0]  pwdata,
   output logic [lab_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   lab_pkg::cmd_type    cmd;
   lab_pkg::status_type status;
   logic                req_ready;

   // The register port never waits.
   assign pready        = 1'b1;
   assign req_bus.ready = req_ready;

   // Sequencing of one sample.
   lab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   lab_datapath #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_now_ms      (req_bus.now_ms),
      .req_lux         (req_bus.lux),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_average_lux (rsp_bus.average_lux),
      .rsp_brightness  (rsp_bus.brightness),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata)
   );
endmodule

@@ rtl/lab_ram.sv @@
// ----------------------------------------------------------------------------
// lab_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lab_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 30
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/lab_div.sv @@
// ----------------------------------------------------------------------------
// lab_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle. Busy is high from the
// cycle after start until the quotient is ready; the quotient then holds.
// ----------------------------------------------------------------------------
module lab_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lab_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [lab_pkg::DIV_DEN_W-1:0] divisor,
   output logic                          busy,
   output logic [lab_pkg::DIV_NUM_W-1:0] quotient
);
   localparam int NUM_W   = lab_pkg::DIV_NUM_W;
   localparam int DEN_W   = lab_pkg::DIV_DEN_W;
   localparam int STEPS   = NUM_W / 2;
   localparam int COUNT_W = $clog2(STEPS);

   logic               busy_ff, busy_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;

   logic [DEN_W:0]     trial1, trial2;
   logic [DEN_W-1:0]   rem1;
   logic [NUM_W-1:0]   quo1, quo2;
   logic               ge1, ge2;

   // Two dependent restoring steps.
   always_comb begin
      trial1 = {rem_ff, quo_ff[NUM_W-1]};
      ge1    = trial1 >= {1'b0, den_ff};
      rem1   = ge1 ? DEN_W'(trial1 - {1'b0, den_ff}) : DEN_W'(trial1);
      quo1   = {quo_ff[NUM_W-2:0], ge1};
      trial2 = {rem1, quo1[NUM_W-1]};
      ge2    = trial2 >= {1'b0, den_ff};
      quo2   = {quo1[NUM_W-2:0], ge2};
   end

   // Sequencing of the iterations.
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = quo2;
         rem_in   = ge2 ? DEN_W'(trial2 - {1'b0, den_ff}) : DEN_W'(trial2);
         count_in = COUNT_W'(count_ff + 1'b1);
         if (count_ff == COUNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   // The divider finishes exactly after its fixed number of iterations.
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && count_ff == COUNT_W'(STEPS - 1)) |=> !busy_ff)
      else $error("divider did not finish after its last iteration");
`endif
endmodule

@@ rtl/lab_ctrl.sv @@
// ----------------------------------------------------------------------------
// lab_ctrl: controller of the lux average brightness map
// Sequences one sample through window update, averaging, range multiply,
// range division (skipped for an empty lux range) and result hand-off.
// ----------------------------------------------------------------------------
module lab_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lab_pkg::status_type status,
   output lab_pkg::cmd_type    cmd
);
   lab_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lab_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         lab_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && status.take) begin
               cmd.capture = 1'b1;
               state_in    = lab_pkg::ST_READ;
            end
         end
         lab_pkg::ST_READ: begin
            cmd.ram_read = 1'b1;
            state_in     = lab_pkg::ST_UPDATE;
         end
         lab_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = lab_pkg::ST_AVERAGE;
         end
         lab_pkg::ST_AVERAGE: begin
            cmd.avg_load = 1'b1;
            state_in     = lab_pkg::ST_MAP_MUL;
         end
         lab_pkg::ST_MAP_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = lab_pkg::ST_MAP_START;
         end
         lab_pkg::ST_MAP_START: begin
            // An empty lux range needs no division.
            if (status.span_zero) begin
               state_in = lab_pkg::ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = lab_pkg::ST_MAP_WAIT;
            end
         end
         lab_pkg::ST_MAP_WAIT: begin
            if (!status.div_busy) begin
               state_in = lab_pkg::ST_FINISH;
            end
         end
         lab_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = lab_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lab_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

@@ rtl/lab_datapath.sv @@
// ----------------------------------------------------------------------------
// lab_datapath: datapath of the lux average brightness map
// Holds the registers, the sample window with its valid bits and running
// sum, the reciprocal multiplier for the average, the range multiplier, the
// iterative range divider and the result register.
// ----------------------------------------------------------------------------
module lab_datapath #(
   parameter int WINDOW_LEN = lab_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lab_pkg::cmd_type               cmd,
   output lab_pkg::status_type            status,
   input  logic [lab_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [lab_pkg::LUX_W-1:0]      req_lux,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [lab_pkg::LUX_W-1:0]      rsp_average_lux,
   output logic [lab_pkg::BRIGHT_W-1:0]   rsp_brightness,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lab_pkg::CSR_AW-1:0]     paddr,
   input  logic [lab_pkg::CSR_DW-1:0]     pwdata,
   output logic [lab_pkg::CSR_DW-1:0]     prdata
);
   localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int TOTAL_W = lab_pkg::LUX_W + $clog2(WINDOW_LEN);
   localparam int LUX_W   = lab_pkg::LUX_W;
   localparam int NUM_W   = lab_pkg::DIV_NUM_W;
   localparam int DEN_W   = lab_pkg::DIV_DEN_W;
   localparam int DIFF_W  = lab_pkg::DIFF_W;
   localparam int SPAN_W  = lab_pkg::SPAN_W;
   localparam int PROD_W  = lab_pkg::PROD_W;
   localparam int RES_W   = NUM_W + 2;

   // Reciprocal of the window length, exact for every sum below 2**TOTAL_W.
   localparam int     AVG_SHIFT  = TOTAL_W + $clog2(WINDOW_LEN);
   localparam int     MUL_W      = TOTAL_W + 2;
   localparam int     AVG_PROD_W = TOTAL_W + MUL_W;
   localparam longint AVG_MUL    = ((longint'(1) << AVG_SHIFT) + longint'(WINDOW_LEN) - 1)
                                   / longint'(WINDOW_LEN);

   // Configuration registers.
   logic [15:0] period_ff, low_ff, high_ff;
   logic [7:0]  floor_ff, ceiling_ff;
   logic        csr_write;
   lab_pkg::reg_index_type csr_index;

   // Sample state.
   logic [lab_pkg::TIME_W-1:0] last_ms_ff;
   logic [LUX_W-1:0]           lux_ff;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [WINDOW_LEN-1:0]      valid_ff;
   logic [TOTAL_W-1:0]         total_ff;
   logic [LUX_W-1:0]           ram_rd_data, old_lux;
   logic [lab_pkg::TIME_W-1:0] elapsed;
   logic [AVG_PROD_W-1:0]      avg_prod;

   // Range map.
   logic [LUX_W-1:0]         avg_ff;
   logic signed [PROD_W-1:0] num_ff;
   logic signed [DIFF_W-1:0] span_ff;
   logic signed [DIFF_W-1:0] diff_in, span_in;
   logic signed [SPAN_W-1:0] out_span_in;
   logic [PROD_W-1:0]        num_mag;
   logic [DIFF_W-1:0]        span_mag;
   logic                     neg;

   // Divider.
   logic [NUM_W-1:0] div_dividend, div_quotient;
   logic [DEN_W-1:0] div_divisor;
   logic             div_busy;

   // Result.
   logic signed [RES_W-1:0] quo_signed, res_sum;
   logic [7:0]              bright_in;
   logic                    rsp_valid_ff;
   logic [LUX_W-1:0]        rsp_avg_ff;
   logic [7:0]              rsp_bright_ff;

   // Register writes and reads.
   assign csr_write = psel && penable && pwrite;
   assign csr_index = lab_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= lab_pkg::PERIOD_RESET;
         low_ff     <= lab_pkg::LOW_RESET;
         high_ff    <= lab_pkg::HIGH_RESET;
         floor_ff   <= lab_pkg::FLOOR_RESET;
         ceiling_ff <= lab_pkg::CEILING_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            lab_pkg::REG_SAMPLE_PERIOD:  period_ff  <= pwdata[15:0];
            lab_pkg::REG_LUX_RANGE_LOW:  low_ff     <= pwdata[15:0];
            lab_pkg::REG_LUX_RANGE_HIGH: high_ff    <= pwdata[15:0];
            lab_pkg::REG_BRIGHT_FLOOR:   floor_ff   <= pwdata[7:0];
            lab_pkg::REG_BRIGHT_CEILING: ceiling_ff <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         lab_pkg::REG_SAMPLE_PERIOD:  prdata = {16'd0, period_ff};
         lab_pkg::REG_LUX_RANGE_LOW:  prdata = {16'd0, low_ff};
         lab_pkg::REG_LUX_RANGE_HIGH: prdata = {16'd0, high_ff};
         lab_pkg::REG_BRIGHT_FLOOR:   prdata = {24'd0, floor_ff};
         lab_pkg::REG_BRIGHT_CEILING: prdata = {24'd0, ceiling_ff};
         default:                     prdata = '0;
      endcase
   end

   // A sample is taken when the wrapped elapsed time exceeds the period.
   assign elapsed     = req_now_ms - last_ms_ff;
   assign status.take = elapsed > {16'd0, period_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ms_ff <= '0;
      end else if (cmd.capture) begin
         last_ms_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lux_ff <= req_lux;
      end
   end

   // Window storage; entries never written count as zero through the valid bits.
   lab_ram #(
      .WIDTH (LUX_W),
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff),
      .wr_data (lux_ff),
      .rd_en   (cmd.ram_read),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign old_lux = valid_ff[slot_ff] ? ram_rd_data : '0;
   assign slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : SLOT_W'(slot_ff + 1'b1);

   // Running sum, valid bits and write slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= '0;
         total_ff <= '0;
      end else if (cmd.update) begin
         slot_ff           <= slot_in;
         valid_ff[slot_ff] <= 1'b1;
         total_ff          <= total_ff - TOTAL_W'(old_lux) + TOTAL_W'(lux_ff);
      end
   end

   // Window average: the sum times the scaled reciprocal of the length.
   assign avg_prod = AVG_PROD_W'(total_ff) * AVG_PROD_W'(AVG_MUL);

   // Signed differences of the range map.
   assign diff_in     = $signed({1'b0, avg_ff}) - $signed({1'b0, low_ff});
   assign span_in     = $signed({1'b0, high_ff}) - $signed({1'b0, low_ff});
   assign out_span_in = $signed({1'b0, ceiling_ff}) - $signed({1'b0, floor_ff});

   always_ff @(posedge clock) begin
      if (cmd.avg_load) begin
         avg_ff <= avg_prod[AVG_SHIFT +: LUX_W];
      end
      if (cmd.mul_load) begin
         num_ff  <= diff_in * out_span_in;
         span_ff <= span_in;
      end
   end

   assign status.span_zero = (span_ff == '0);
   assign num_mag  = num_ff[PROD_W-1] ? PROD_W'(-num_ff) : PROD_W'(num_ff);
   assign span_mag = span_ff[DIFF_W-1] ? DIFF_W'(-span_ff) : DIFF_W'(span_ff);
   assign neg      = num_ff[PROD_W-1] ^ span_ff[DIFF_W-1];

   // Range divider operands: magnitudes of the product and the lux span.
   assign div_dividend = num_mag[NUM_W-1:0];
   assign div_divisor  = span_mag[DEN_W-1:0];

   lab_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign status.div_busy = div_busy;

   // Brightness: signed quotient plus floor, saturated to a byte; the floor alone for an empty lux range.
   always_comb begin
      quo_signed = neg ? -$signed({2'b00, div_quotient}) : $signed({2'b00, div_quotient});
      res_sum    = quo_signed + $signed({{(RES_W - 8){1'b0}}, floor_ff});
      if (status.span_zero) begin
         bright_in = floor_ff;
      end else if (res_sum[RES_W-1]) begin
         bright_in = 8'd0;
      end else if (res_sum > $signed(RES_W'(255))) begin
         bright_in = 8'd255;
      end else begin
         bright_in = res_sum[7:0];
      end
   end

   // Result register.
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_avg_ff    <= avg_ff;
         rsp_bright_ff <= bright_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average_lux = rsp_avg_ff;
   assign rsp_brightness  = rsp_bright_ff;

`ifndef SYNTHESIS
   // An empty window always has a zero running sum.
   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0) |-> (total_ff == '0))
      else $error("running sum is not zero for an empty window");

   // The write slot never leaves the window.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW_LEN - 1))
      else $error("write slot outside the window");

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while waiting");

   // A division started is seen as busy by the controller.
   a_div_started: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider not busy after start");
`endif
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the lux average brightness map
// Drives time-stamped light readings and register writes into the block. A
// predictor in the bench keeps its own sample window and settings and forms
// each expected result word. Every result word is checked against the oldest
// prediction, field by field; channels idle at random until the last phase.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WINDOW_LEN   = lab_pkg::WINDOW_LEN_DEFAULT;
   localparam int IDLE_CYCLES  = 64;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam int REG_SLOTS    = 1 << $bits(lab_pkg::reg_index_type);
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 90;
   localparam int BURST_LEN    = 45;
   localparam int LUX_MAX      = (1 << lab_pkg::LUX_W) - 1;
   localparam int BRIGHT_MAX   = (1 << lab_pkg::BRIGHT_W) - 1;

   // Lux patterns of the random part.
   typedef enum int {
      LUX_ANY,
      LUX_ANY_TOO,
      LUX_FULL_SCALE,
      LUX_DARK,
      LUX_NEAR_RANGE
   } lux_mode_type;

   typedef struct packed {
      logic [lab_pkg::LUX_W-1:0]    average_lux;
      logic [lab_pkg::BRIGHT_W-1:0] brightness;
   } level_word_type;

   logic                         clock;
   logic                         reset;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [lab_pkg::CSR_AW-1:0]   paddr;
   logic [lab_pkg::CSR_DW-1:0]   pwdata;
   logic [lab_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;
   logic                         holding = 1'b0;
   logic                         calm = 1'b0;
   event                         hold_kick;

   lab_req_if req_bus ();
   lab_rsp_if rsp_bus ();

   lux_average_brightness_map #(
      .WINDOW_LEN (WINDOW_LEN)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state: settings, sample window and the queue of coming words.
   logic [15:0]               cfg_period;
   logic [15:0]               cfg_low;
   logic [15:0]               cfg_high;
   logic [7:0]                cfg_floor;
   logic [7:0]                cfg_ceiling;
   logic [lab_pkg::LUX_W-1:0] window_lux [WINDOW_LEN];
   int                        fill_slot;
   logic [20:0]               window_sum;
   logic [31:0]               last_sample_ms;
   logic [31:0]               now_stamp;
   level_word_type            pending_levels [$];

   int                readings_sent = 0;
   int                samples_taken = 0;
   int                words_checked = 0;
   int                csr_writes = 0;
   int                settings_used = 0;
   int                mismatches = 0;
   int                cycle_count = 0;

   // Clock with a 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Cycle limit guards against a hung handshake.
   initial begin
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run exceeded %0d cycles with %0d words outstanding", CYCLE_LIMIT,
               pending_levels.size());
      $display("TEST FAILED");
      $finish;
   end

   // Long receiver hold, started on request and timed here in cycles.
   initial begin
      forever begin
         @(hold_kick);
         @(posedge clock);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   // Report a wrong value; only the first few are printed.
   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch on %s: expected %0d, actual %0d", what, want, got);
      end
   endtask

   // Map a window average onto the brightness range, saturated to a byte.
   function automatic logic [7:0] map_to_brightness(input logic [15:0] avg);
      longint lo;
      longint hi;
      longint fl;
      longint ce;
      longint av;
      longint level;
      lo = cfg_low;
      hi = cfg_high;
      fl = cfg_floor;
      ce = cfg_ceiling;
      av = avg;
      if (hi == lo) begin
         level = fl;
      end else begin
         level = (av - lo) * (ce - fl) / (hi - lo) + fl;
      end
      if (level < 0) begin
         level = 0;
      end else if (level > BRIGHT_MAX) begin
         level = BRIGHT_MAX;
      end
      return level[7:0];
   endfunction

   // Take a reading into the window if enough time has passed since the last one.
   task automatic predict_reading(input logic [31:0] now, input logic [15:0] lux);
      logic [31:0]    elapsed;
      level_word_type word;
      elapsed = now - last_sample_ms;
      if (elapsed > {16'd0, cfg_period}) begin
         last_sample_ms = now;
         window_sum = window_sum - window_lux[fill_slot] + lux;
         window_lux[fill_slot] = lux;
         fill_slot = (fill_slot == WINDOW_LEN - 1) ? 0 : fill_slot + 1;
         word.average_lux = 16'(window_sum / WINDOW_LEN);
         word.brightness = map_to_brightness(word.average_lux);
         pending_levels.push_back(word);
         samples_taken++;
      end
   endtask

   // Compare one result word with the oldest prediction.
   task automatic check_level_word(input logic [15:0] avg, input logic [7:0] bright);
      level_word_type want;
      if (pending_levels.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("result word with none expected: average %0d, brightness %0d",
                     avg, bright);
         end
      end else begin
         want = pending_levels.pop_front();
         words_checked++;
         if (avg !== want.average_lux) begin
            report_mismatch("average_lux", want.average_lux, avg);
         end
         if (bright !== want.brightness) begin
            report_mismatch("brightness", want.brightness, bright);
         end
      end
   endtask

   // Result side: check accepted words and idle the receiver in bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            check_level_word(rsp_bus.average_lux, rsp_bus.brightness);
         end
         if (holding) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one reading word, at times with a random gap ahead of it, and predict it.
   task automatic send_reading(input logic [31:0] now, input logic [15:0] lux);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.now_ms <= now;
      req_bus.lux    <= lux;
      do @(posedge clock); while (!req_bus.ready);
      predict_reading(now, lux);
      readings_sent++;
   endtask

   // Advance the time stamp by a step and send a reading.
   task automatic step_reading(input logic [31:0] step, input logic [15:0] lux);
      now_stamp = now_stamp + step;
      send_reading(now_stamp, lux);
   endtask

   // Send a reading at the sample period boundary plus an offset.
   task automatic boundary_reading(input logic [31:0] extra, input logic [15:0] lux);
      now_stamp = last_sample_ms + cfg_period + extra;
      send_reading(now_stamp, lux);
   endtask

   // Stop sending and wait until the block has nothing left to do.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup phase, access phase until pready, then an idle phase.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (index)
         lab_pkg::REG_SAMPLE_PERIOD:  cfg_period  = value[15:0];
         lab_pkg::REG_LUX_RANGE_LOW:  cfg_low     = value[15:0];
         lab_pkg::REG_LUX_RANGE_HIGH: cfg_high    = value[15:0];
         lab_pkg::REG_BRIGHT_FLOOR:   cfg_floor   = value[7:0];
         lab_pkg::REG_BRIGHT_CEILING: cfg_ceiling = value[7:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Read a register back and compare it with the predictor's copy.
   task automatic check_register(input logic [2:0] index);
      logic [31:0] want;
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (index)
         lab_pkg::REG_SAMPLE_PERIOD:  want = {16'd0, cfg_period};
         lab_pkg::REG_LUX_RANGE_LOW:  want = {16'd0, cfg_low};
         lab_pkg::REG_LUX_RANGE_HIGH: want = {16'd0, cfg_high};
         lab_pkg::REG_BRIGHT_FLOOR:   want = {24'd0, cfg_floor};
         lab_pkg::REG_BRIGHT_CEILING: want = {24'd0, cfg_ceiling};
         default:                     want = got;
      endcase
      if (got !== want) begin
         report_mismatch($sformatf("register %0d readback", index), want, got);
      end
   endtask

   task automatic check_all_registers();
      for (int i = 0; i <= int'(lab_pkg::REG_BRIGHT_CEILING); i++) begin
         check_register(3'(i));
      end
   endtask

   // Load a full set of settings once the block is idle.
   task automatic set_registers(input logic [15:0] period, input logic [15:0] low,
                                input logic [15:0] high, input logic [7:0] floor_level,
                                input logic [7:0] ceiling_level);
      wait_idle();
      csr_write(lab_pkg::REG_SAMPLE_PERIOD, {16'd0, period});
      csr_write(lab_pkg::REG_LUX_RANGE_LOW, {16'd0, low});
      csr_write(lab_pkg::REG_LUX_RANGE_HIGH, {16'd0, high});
      csr_write(lab_pkg::REG_BRIGHT_FLOOR, {24'd0, floor_level});
      csr_write(lab_pkg::REG_BRIGHT_CEILING, {24'd0, ceiling_level});
      settings_used++;
   endtask

   // Reset values, then items early, exactly on the period, late and across the wrap.
   task automatic test_reset_values();
      check_all_registers();
      step_reading(32'd0, 16'd100);
      step_reading(32'd200, 16'd200);
      step_reading(32'd1, 16'hFFFF);
      step_reading(32'd201, 16'd0);
      step_reading(32'd200, 16'd12345);
      step_reading(32'hFFFF_FF00 - now_stamp, 16'hFFFF);
      step_reading(32'h0000_0110, 16'h5555);
      step_reading(32'd200, 16'hAAAA);
   endtask

   // Register extremes with junk in the upper bits, and writes to unused slots.
   task automatic test_register_space();
      wait_idle();
      csr_write(lab_pkg::REG_SAMPLE_PERIOD, 32'hA5A5_FFFF);
      csr_write(lab_pkg::REG_LUX_RANGE_LOW, 32'h5A5A_FFFF);
      csr_write(lab_pkg::REG_LUX_RANGE_HIGH, 32'hFFFF_0000);
      csr_write(lab_pkg::REG_BRIGHT_FLOOR, 32'hFFFF_FFFF);
      csr_write(lab_pkg::REG_BRIGHT_CEILING, 32'hFFFF_FF00);
      settings_used++;
      check_all_registers();
      for (int i = int'(lab_pkg::REG_BRIGHT_CEILING) + 1; i < REG_SLOTS; i++) begin
         csr_write(3'(i), 32'hFFFF_FFFF);
      end
      check_all_registers();
      // Longest period, reversed lux range and falling brightness.
      boundary_reading(32'd0, 16'h1234);
      boundary_reading(32'd1, 16'hFFFF);
      boundary_reading(32'd1, 16'h0001);
   endtask

   // Empty range, saturation on both sides and a falling brightness scale.
   task automatic test_range_shapes();
      set_registers(16'd0, 16'd500, 16'd500, 8'd37, 8'd200);
      boundary_reading(32'd1, 16'(LUX_MAX));
      boundary_reading(32'd0, 16'd7);
      boundary_reading(32'd1, 16'd4000);
      set_registers(16'd0, 16'd1000, 16'd1010, 8'd0, 8'd255);
      boundary_reading(32'd1, 16'(LUX_MAX));
      boundary_reading(32'd1, 16'(LUX_MAX));
      set_registers(16'd0, 16'd60000, 16'd60010, 8'd0, 8'd255);
      boundary_reading(32'd1, 16'd0);
      set_registers(16'd200, 16'd0, 16'(LUX_MAX), 8'd200, 8'd10);
      boundary_reading(32'd1, 16'd30000);
      boundary_reading(32'd1, 16'(LUX_MAX));
   endtask

   // Hold the receiver off while readings keep coming, so the block backs up.
   task automatic test_back_pressure();
      set_registers(lab_pkg::PERIOD_RESET, lab_pkg::LOW_RESET, lab_pkg::HIGH_RESET,
                    lab_pkg::FLOOR_RESET, lab_pkg::CEILING_RESET);
      -> hold_kick;
      for (int i = 0; i < 8; i++) begin
         boundary_reading(32'($urandom_range(1, 50)), 16'($urandom_range(0, LUX_MAX)));
      end
      wait_idle();
   endtask

   // Pick a lux value for the current pattern.
   function automatic logic [15:0] pick_lux(input lux_mode_type mode);
      int center;
      case (mode)
         LUX_FULL_SCALE: return 16'(LUX_MAX);
         LUX_DARK:       return 16'd0;
         LUX_NEAR_RANGE: begin
            center = (int'(cfg_low) + int'(cfg_high)) / 2 + $urandom_range(0, 4000) - 2000;
            if (center < 0) center = 0;
            if (center > LUX_MAX) center = LUX_MAX;
            return 16'(center);
         end
         default:        return 16'($urandom_range(0, LUX_MAX));
      endcase
   endfunction

   // Settings for one phase: extremes first, then reset values, then random ones.
   task automatic choose_settings(input int phase);
      logic [15:0] period;
      logic [15:0] low;
      logic [15:0] high;
      case (phase)
         0: set_registers(16'd0, 16'd0, 16'(LUX_MAX), 8'd0, 8'd255);
         1: set_registers(16'(LUX_MAX), 16'(LUX_MAX), 16'd0, 8'd255, 8'd0);
         2: set_registers(lab_pkg::PERIOD_RESET, lab_pkg::LOW_RESET, lab_pkg::HIGH_RESET,
                          lab_pkg::FLOOR_RESET, lab_pkg::CEILING_RESET);
         default: begin
            period = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16))
                                                 : 16'($urandom_range(0, 1000));
            case ($urandom_range(0, 3))
               0: begin
                  low = 16'($urandom_range(0, LUX_MAX));
                  high = 16'($urandom_range(0, LUX_MAX));
               end
               1: begin
                  low = 16'($urandom_range(0, LUX_MAX));
                  high = low;
               end
               default: begin
                  low = 16'($urandom_range(0, 40000));
                  high = low + 16'($urandom_range(1, 20000));
                  if ($urandom_range(0, 2) == 0) begin
                     {low, high} = {high, low};
                  end
               end
            endcase
            set_registers(period, low, high, 8'($urandom_range(0, BRIGHT_MAX)),
                          8'($urandom_range(0, BRIGHT_MAX)));
         end
      endcase
   endtask

   // Random phases: mostly timely readings, some early, exact or far jumps.
   task automatic test_random_phases();
      int           pick;
      lux_mode_type mode;
      mode = LUX_ANY;
      for (int phase = 0; phase < PHASES; phase++) begin
         choose_settings(phase);
         // The last phase runs without idling on either side.
         if (phase == PHASES - 1) calm <= 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % BURST_LEN == 0) mode = lux_mode_type'($urandom_range(0, 4));
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
               step_reading(32'(cfg_period) + 32'd1 + 32'($urandom_range(0, 400)),
                            pick_lux(mode));
            end else if (pick < 88) begin
               step_reading(32'($urandom_range(0, cfg_period)), pick_lux(mode));
            end else if (pick < 94) begin
               boundary_reading(32'($urandom_range(0, 1)), pick_lux(mode));
            end else begin
               step_reading($urandom(), pick_lux(mode));
            end
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.now_ms <= '0;
      req_bus.lux    <= '0;
      cfg_period     = lab_pkg::PERIOD_RESET;
      cfg_low        = lab_pkg::LOW_RESET;
      cfg_high       = lab_pkg::HIGH_RESET;
      cfg_floor      = lab_pkg::FLOOR_RESET;
      cfg_ceiling    = lab_pkg::CEILING_RESET;
      for (int i = 0; i < WINDOW_LEN; i++) window_lux[i] = '0;
      fill_slot      = 0;
      window_sum     = '0;
      last_sample_ms = '0;
      now_stamp      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_register_space();
      test_range_shapes();
      test_back_pressure();
      test_random_phases();

      // Drain the last words and let the block settle.
      wait_idle();
      $display("sent %0d readings, %0d sampled, %0d words checked", readings_sent,
               samples_taken, words_checked);
      $display("%0d register writes over %0d settings, %0d mismatches", csr_writes,
               settings_used, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lab_pkg.sv
rtl/lab_req_if.sv
rtl/lab_rsp_if.sv
rtl/lab_ram.sv
rtl/lab_div.sv
rtl/lab_ctrl.sv
rtl/lab_datapath.sv
rtl/lux_average_brightness_map.sv
tb/testbench.sv
